/* rtl/consistent_hash_ring_top_macros.svh */
// assertion macros for the consistent hash ring
// no dependencies
`ifndef CONSISTENT_HASH_RING_TOP_MACROS_SVH
`define CONSISTENT_HASH_RING_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CHR_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHR_ASSERT(lbl, clk, rst, prop, msg)
`define CHR_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

/* rtl/chr_pkg.sv */
// package for the consistent hash ring: request and response types, codes
// no dependencies
`timescale 1ns / 1ps
package chr_pkg;
   localparam int MaxVnodes = 256;
   localparam int MaxNodes  = 16;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_DUP   = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] position;
      logic [3:0]  node_index;
      logic [63:0] key_hash;
      logic [4:0]  replica_count;
   } req_type;

   typedef struct packed {
      logic [3:0] owner;
      logic [3:0] rank;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH_RD, S_SRCH_WAIT, S_SRCH_CMP, S_DECIDE,
      S_SHIFT_RD, S_SHIFT_WAIT, S_SHIFT_WR, S_PUT,
      S_REM_RD, S_REM_WAIT, S_REM_WR, S_WALK_RD, S_WALK_WAIT, S_WALK_CHK, S_OUT
   } state_type;
endpackage

/* rtl/chr_ram.sv */
// generic single-port-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module chr_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

/* rtl/consistent_hash_ring_top.sv */
// consistent hash ring: sorted virtual node table, sequencer and ram instances
// depends on chr_pkg, chr_ram and consistent_hash_ring_top_macros.svh
//
// usage: one request channel (req_valid/req_stall/req_data) carries insert,
// remove or lookup; one response channel (rsp_valid/rsp_stall/rsp_data) gives
// one response for insert, remove, unused op and empty ring, and one per
// distinct owner for a lookup, the final one marked by last.
// a request is taken only when the sequencer is idle and no response waits;
// req_stall is high while a request is at work or a response is held.
// a binary search over the table takes up to log2(MAX_VNODES)+1 probes;
// insert then shifts the tail up entry by entry, remove compacts the whole
// table, lookup walks the ring entry by entry plus an output step per owner;
// each probe or entry takes a read, a wait and a compare, write or check state.
// everything goes through one read port of the table ram, which sets the rate.
// reset empties the table (count and present mask cleared); no clearing pass.
// when the receiver stalls, the response holds in the output register and
// the sequencer waits before it gives the next response.
`timescale 1ns / 1ps
`include "consistent_hash_ring_top_macros.svh"
module consistent_hash_ring_top #(
   parameter int MAX_VNODES = chr_pkg::MaxVnodes,
   parameter int MAX_NODES  = chr_pkg::MaxNodes
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  chr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output chr_pkg::rsp_type rsp_data
);
   import chr_pkg::*;

   localparam int AW = $clog2(MAX_VNODES);
   localparam int CW = AW + 1;
   localparam int NW = (MAX_NODES > 16) ? MAX_NODES : 16;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [NW-1:0] present_ff, present_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] idx_ff, idx_in, ptr_ff, ptr_in, walk_ff, walk_in;
   logic [15:0]   seen_ff, seen_in;
   logic [4:0]    want_ff, want_in, n_ff, n_in;
   logic [3:0]    own_ff, own_in;
   logic          valid_ff, valid_in;
   rsp_type       out_ff, out_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_pos, rd_pos;
   logic [3:0]    wr_own, rd_own;

   chr_ram #(.Width(64), .Depth(MAX_VNODES)) u_pos (
      .clock, .wr_en, .wr_addr, .wr_data(wr_pos), .rd_addr, .rd_data(rd_pos));
   chr_ram #(.Width(4), .Depth(MAX_VNODES)) u_own (
      .clock, .wr_en, .wr_addr, .wr_data(wr_own), .rd_addr, .rd_data(rd_own));

   logic [CW-1:0] mid;
   logic [63:0]   search_key;
   logic [4:0]    avail;
   logic [4:0]    want_c;
   logic          node_ok;

   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign search_key = (req_ff.op == OP_INSERT) ? req_ff.position : req_ff.key_hash;
   assign node_ok    = (32'(req_ff.node_index) < MAX_NODES);

   always_comb begin
      avail = '0;
      for (int i = 0; i < 16; i++) avail = avail + 5'(present_ff[i]);
   end

   always_comb begin
      want_c = (req_ff.replica_count == 5'd0) ? 5'd1 : req_ff.replica_count;
      if (want_c > avail) want_c = avail;
   end

   assign req_stall = (state_ff != S_IDLE) || valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         present_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         present_ff <= present_in;
         valid_ff   <= valid_in;
      end
      req_ff      <= req_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      idx_ff      <= idx_in;
      ptr_ff      <= ptr_in;
      walk_ff     <= walk_in;
      seen_ff     <= seen_in;
      want_ff     <= want_in;
      n_ff        <= n_in;
      own_ff      <= own_in;
      out_ff      <= out_in;
   end

   task automatic respond(input logic [3:0] o, input logic [3:0] r,
                          input logic [1:0] s, input logic l);
      out_in   = '{owner: o, rank: r, status: s, last: l};
      valid_in = 1'b1;
   endtask

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      count_in    = count_ff;
      present_in  = present_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      idx_in      = idx_ff;
      ptr_in      = ptr_ff;
      walk_in     = walk_ff;
      seen_in     = seen_ff;
      want_in     = want_ff;
      n_in        = n_ff;
      own_in      = own_ff;
      out_in      = out_ff;
      valid_in    = valid_ff && rsp_stall;
      wr_en       = 1'b0;
      wr_addr     = ptr_ff[AW-1:0];
      wr_pos      = rd_pos;
      wr_own      = 4'd0;
      rd_addr     = mid[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               req_in = req_data;
               lo_in  = '0;
               hi_in  = count_ff;
               unique case (req_data.op)
                  OP_INSERT: state_in = S_SRCH_RD;
                  OP_REMOVE: begin
                     ptr_in   = '0;
                     walk_in  = '0;
                     state_in = S_REM_RD;
                  end
                  OP_LOOKUP: begin
                     if (count_ff == '0) respond(4'd0, 4'd0, ST_EMPTY, 1'b1);
                     else state_in = S_SRCH_RD;
                  end
                  default: respond(4'd0, 4'd0, ST_OK, 1'b1);
               endcase
            end
         end
         S_SRCH_RD: begin
            if (lo_ff < hi_ff) state_in = S_SRCH_WAIT;
            else state_in = S_DECIDE;
            // probe the entry just below the found slot for the duplicate test
            if (!(lo_ff < hi_ff)) rd_addr = AW'(lo_ff - CW'(1));
         end
         S_SRCH_WAIT: begin
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            if (rd_pos > search_key) hi_in = mid;
            else lo_in = mid + CW'(1);
            state_in = S_SRCH_RD;
         end
         S_DECIDE: begin
            // rd_pos holds entry lo-1 here
            idx_in = lo_ff;
            if (req_ff.op == OP_INSERT) begin
               if (!node_ok || count_ff >= CW'(MAX_VNODES)) begin
                  respond(4'd0, 4'd0, ST_FULL, 1'b1);
                  state_in = S_IDLE;
               end else if (lo_ff != '0 && rd_pos == req_ff.position) begin
                  respond(4'd0, 4'd0, ST_DUP, 1'b1);
                  state_in = S_IDLE;
               end else begin
                  ptr_in   = count_ff;
                  state_in = S_SHIFT_RD;
               end
            end else begin
               want_in  = want_c;
               n_in     = '0;
               seen_in  = '0;
               walk_in  = '0;
               if (lo_ff >= count_ff) idx_in = '0;
               state_in = S_WALK_RD;
            end
         end
         S_SHIFT_RD: begin
            rd_addr = AW'(ptr_ff - CW'(1));
            if (ptr_ff > idx_ff) state_in = S_SHIFT_WAIT;
            else state_in = S_PUT;
         end
         S_SHIFT_WAIT: begin
            rd_addr  = AW'(ptr_ff - CW'(1));
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_pos   = rd_pos;
            wr_own   = rd_own;
            ptr_in   = ptr_ff - CW'(1);
            state_in = S_SHIFT_RD;
         end
         S_PUT: begin
            wr_en      = 1'b1;
            wr_addr    = idx_ff[AW-1:0];
            wr_pos     = req_ff.position;
            wr_own     = req_ff.node_index;
            count_in   = count_ff + CW'(1);
            present_in = present_ff | (NW'(1) << req_ff.node_index);
            respond(4'd0, 4'd0, ST_OK, 1'b1);
            state_in   = S_IDLE;
         end
         S_REM_RD: begin
            rd_addr = walk_ff[AW-1:0];
            if (!node_ok) begin
               respond(4'd0, 4'd0, ST_OK, 1'b1);
               state_in = S_IDLE;
            end else if (walk_ff < count_ff) begin
               state_in = S_REM_WAIT;
            end else begin
               count_in   = ptr_ff;
               present_in = present_ff & ~(NW'(1) << req_ff.node_index);
               respond(4'd0, 4'd0, ST_OK, 1'b1);
               state_in   = S_IDLE;
            end
         end
         S_REM_WAIT: begin
            rd_addr  = walk_ff[AW-1:0];
            state_in = S_REM_WR;
         end
         S_REM_WR: begin
            if (rd_own != req_ff.node_index) begin
               wr_en  = 1'b1;
               wr_pos = rd_pos;
               wr_own = rd_own;
               ptr_in = ptr_ff + CW'(1);
            end
            walk_in  = walk_ff + CW'(1);
            state_in = S_REM_RD;
         end
         S_WALK_RD: begin
            rd_addr = idx_ff[AW-1:0];
            if (walk_ff < count_ff && n_ff < want_ff) state_in = S_WALK_WAIT;
            else begin
               if (n_ff == '0) respond(4'd0, 4'd0, ST_EMPTY, 1'b1);
               state_in = S_IDLE;
            end
         end
         S_WALK_WAIT: begin
            rd_addr  = idx_ff[AW-1:0];
            state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            walk_in  = walk_ff + CW'(1);
            idx_in   = (idx_ff + CW'(1) >= count_ff) ? '0 : idx_ff + CW'(1);
            state_in = S_WALK_RD;
            if (!seen_ff[rd_own]) begin
               seen_in  = seen_ff | (16'd1 << rd_own);
               n_in     = n_ff + 5'd1;
               own_in   = rd_own;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // wait for the previous owner to leave the output register
            if (!valid_ff || !rsp_stall) begin
               // last when count reached or no more entries to visit
               respond(own_ff, 4'(n_ff - 5'd1), ST_OK,
                       (n_ff >= want_ff) || (walk_ff >= count_ff));
               state_in = (n_ff >= want_ff || walk_ff >= count_ff) ? S_IDLE : S_WALK_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   `CHR_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(MAX_VNODES), "entry count overflow")
   `CHR_ASSERT(a_idle_no_stall, clock, reset, (state_ff == S_IDLE && !valid_ff) |-> !req_stall, "idle but stalled")
   `CHR_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> ($stable(rsp_data) && rsp_valid), "response changed while stalled")
endmodule
